FILE: design/tmwf_pkg.sv
// Package for the trimmed mean window filter.
// Holds the controller state type and fixed field widths; no dependencies.
package tmwf_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned MeanW   = 24;
  localparam int unsigned CfgW    = 6;
  localparam int unsigned FracW   = 8;
  localparam int unsigned MinLen  = 3;
  localparam int unsigned WinLenReset = 20;
  localparam int unsigned NumAxes = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIVS,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [MeanW-1:0]   mean_t;

endpackage

FILE: design/tmwf_if.sv
// Channel interfaces of the trimmed mean window filter.
// Depends on tmwf_pkg for field types.
interface tmwf_in_if;
  logic                valid;
  logic                ready;
  tmwf_pkg::sample_t   x_sample;
  tmwf_pkg::sample_t   y_sample;
  tmwf_pkg::sample_t   z_sample;
  modport source (output valid, x_sample, y_sample, z_sample, input ready);
  modport sink   (input valid, x_sample, y_sample, z_sample, output ready);
endinterface

interface tmwf_out_if;
  logic              valid;
  logic              ready;
  tmwf_pkg::mean_t   x_mean;
  tmwf_pkg::mean_t   y_mean;
  tmwf_pkg::mean_t   z_mean;
  modport source (output valid, x_mean, y_mean, z_mean, input ready);
  modport sink   (input valid, x_mean, y_mean, z_mean, output ready);
endinterface

interface tmwf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tmwf_pkg::CfgW-1:0]         window_len;
  modport source (output valid, window_len, input ready);
  modport sink   (input valid, window_len, output ready);
endinterface

FILE: design/tmwf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tmwf_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/tmwf_div.sv
// Bit-serial signed divider by a small unsigned divisor, truncating toward zero.
// Depends on tmwf_pkg for the result width.
module tmwf_div #(
  parameter int unsigned DW = 30,
  parameter int unsigned NW = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [DW-1:0] dividend_i,
  input  logic [NW-1:0]        divisor_i,
  output logic                 done_o,
  output tmwf_pkg::mean_t      quot_o
);

  localparam int unsigned CntW = $clog2(DW + 1);

  logic [DW-1:0]   quo_q;
  logic [NW-1:0]   rem_q;
  logic [NW-1:0]   dvs_q;
  logic            neg_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [NW:0]     trial;
  logic [NW:0]     diff;
  logic [DW-1:0]   signed_quo;

  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DW-1];
      quo_q <= dividend_i[DW-1] ? DW'(-dividend_i) : DW'(dividend_i);
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[NW]) begin
        rem_q <= diff[NW-1:0];
        quo_q <= {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_q <= trial[NW-1:0];
        quo_q <= {quo_q[DW-2:0], 1'b0};
      end
    end
  end

  assign signed_quo = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign quot_o     = signed_quo[tmwf_pkg::MeanW-1:0];
  assign done_o     = done_q;

  property p_no_restart;
    @(posedge clk_i) disable iff (!rst_ni) busy_q |-> !start_i;
  endproperty
  a_no_restart: assert property (p_no_restart) else $error("divider restarted while busy");

  property p_done_after_busy;
    @(posedge clk_i) disable iff (!rst_ni) done_q |-> $past(busy_q);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("done without work");

  property p_done_single;
    @(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q;
  endproperty
  a_done_single: assert property (p_done_single) else $error("done while busy");

endmodule

FILE: design/trimmed_mean_window_filter_xyz_core.sv
// Trimmed mean window filter over X/Y/Z samples, top level.
// Depends on tmwf_pkg, tmwf_if, tmwf_ram and tmwf_div.
//
// Channels: in_if takes one X/Y/Z sample request, out_if gives one
// trimmed mean request (Q15.8 per axis), cfg_if writes window_len while idle.
// Requests are taken when valid and ready are both high.
// Each sample is written into a ring RAM of MAX_WINDOW entries (one
// 48-bit word per slot). Until n = clamp(window_len, 3, MAX_WINDOW)
// samples have arrived, no result is given. After that each sample
// starts a scan that reads the n slots through the RAM's single read
// port, accumulating sum, min and max per axis; three bit-serial
// dividers then divide sum - min - max by n - 2 for each axis. One item
// is processed at a time.
// The result is held until out_if.ready; no new sample is taken meanwhile,
// nor while a window_len write is offered.
// Reset clears the fill state and sets window_len to 20; ring contents
// need no clearing. A window_len write restarts filling.
module trimmed_mean_window_filter_xyz_core #(
  parameter int unsigned MAX_WINDOW = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tmwf_in_if.sink     in_if,
  tmwf_out_if.source  out_if,
  tmwf_cfg_if.sink    cfg_if
);

  localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned NW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CW = (NW > tmwf_pkg::CfgW) ? NW : tmwf_pkg::CfgW;
  localparam int unsigned SW = tmwf_pkg::SampleW + NW;
  localparam int unsigned DW = SW + tmwf_pkg::FracW;
  localparam int unsigned RW = tmwf_pkg::SampleW * tmwf_pkg::NumAxes;

  tmwf_pkg::state_e state_q, state_d;

  logic [tmwf_pkg::CfgW-1:0] win_len_q;
  logic [AW-1:0]             wr_idx_q;
  logic                      filled_q;
  logic [NW-1:0]             n_len;
  logic [CW-1:0]             wl_ext;
  logic [AW-1:0]             slot;
  logic                      slot_last;
  logic                      in_take;
  logic                      cfg_take;

  logic [NW-1:0]             rd_cnt_q;
  logic                      dv_q;
  logic                      last_q;
  logic                      first_q;
  logic                      issue;
  logic [RW-1:0]             rdata;

  logic signed [SW-1:0]      sum_q [tmwf_pkg::NumAxes];
  tmwf_pkg::sample_t         min_q [tmwf_pkg::NumAxes];
  tmwf_pkg::sample_t         max_q [tmwf_pkg::NumAxes];
  tmwf_pkg::mean_t           mean_q [tmwf_pkg::NumAxes];
  tmwf_pkg::mean_t           quot [tmwf_pkg::NumAxes];
  logic                      div_done [tmwf_pkg::NumAxes];
  logic                      div_start;

  assign wl_ext = CW'(win_len_q);
  always_comb begin
    priority if (wl_ext < CW'(tmwf_pkg::MinLen)) begin
      n_len = NW'(tmwf_pkg::MinLen);
    end else if (wl_ext > CW'(MAX_WINDOW)) begin
      n_len = NW'(MAX_WINDOW);
    end else begin
      n_len = NW'(wl_ext);
    end
  end

  assign slot      = (NW'(wr_idx_q) >= n_len) ? '0 : wr_idx_q;
  assign slot_last = (NW'(slot) + 1'b1) >= n_len;
  assign in_take   = in_if.valid && in_if.ready;
  assign cfg_take  = cfg_if.valid && cfg_if.ready;
  assign issue     = (state_q == tmwf_pkg::ST_SCAN) && (rd_cnt_q < n_len);
  assign div_start = (state_q == tmwf_pkg::ST_DIVS);

  tmwf_ram #(
    .Width (RW),
    .Depth (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_take),
    .waddr_i (slot),
    .wdata_i ({in_if.x_sample, in_if.y_sample, in_if.z_sample}),
    .raddr_i (rd_cnt_q[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tmwf_pkg::ST_IDLE: begin
        if (in_take && (filled_q || slot_last)) begin
          state_d = tmwf_pkg::ST_SCAN;
        end
      end
      tmwf_pkg::ST_SCAN: begin
        if (dv_q && last_q) begin
          state_d = tmwf_pkg::ST_DIVS;
        end
      end
      tmwf_pkg::ST_DIVS: state_d = tmwf_pkg::ST_DIV;
      tmwf_pkg::ST_DIV: begin
        if (div_done[0]) begin
          state_d = tmwf_pkg::ST_OUT;
        end
      end
      tmwf_pkg::ST_OUT: begin
        if (out_if.ready) begin
          state_d = tmwf_pkg::ST_IDLE;
        end
      end
      default: state_d = tmwf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready  = (state_q == tmwf_pkg::ST_IDLE) && !cfg_if.valid;
    out_if.valid = (state_q == tmwf_pkg::ST_OUT);
    cfg_if.ready = (state_q == tmwf_pkg::ST_IDLE);
  end

  assign out_if.x_mean = mean_q[0];
  assign out_if.y_mean = mean_q[1];
  assign out_if.z_mean = mean_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tmwf_pkg::ST_IDLE;
      win_len_q <= tmwf_pkg::CfgW'(tmwf_pkg::WinLenReset);
      wr_idx_q  <= '0;
      filled_q  <= 1'b0;
      rd_cnt_q  <= '0;
      dv_q      <= 1'b0;
      last_q    <= 1'b0;
      first_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      dv_q    <= issue;
      last_q  <= issue && ((rd_cnt_q + 1'b1) == n_len);
      if (cfg_take) begin
        win_len_q <= cfg_if.window_len;
        wr_idx_q  <= '0;
        filled_q  <= 1'b0;
      end else if (in_take) begin
        wr_idx_q <= slot_last ? '0 : slot + 1'b1;
        if (slot_last) begin
          filled_q <= 1'b1;
        end
      end
      if (in_take) begin
        rd_cnt_q <= '0;
        first_q  <= 1'b1;
      end else begin
        if (issue) begin
          rd_cnt_q <= rd_cnt_q + 1'b1;
        end
        if (dv_q) begin
          first_q <= 1'b0;
        end
      end
    end
  end

  for (genvar a = 0; a < tmwf_pkg::NumAxes; a++) begin : g_axis
    tmwf_pkg::sample_t    smp;
    logic signed [SW-1:0] trim;
    logic signed [DW-1:0] dvd;

    assign smp  = rdata[RW-1-a*tmwf_pkg::SampleW -: tmwf_pkg::SampleW];
    assign trim = sum_q[a] - SW'(min_q[a]) - SW'(max_q[a]);
    assign dvd  = {trim, {tmwf_pkg::FracW{1'b0}}};

    always_ff @(posedge clk_i) begin
      if (dv_q) begin
        if (first_q) begin
          sum_q[a] <= SW'(smp);
          min_q[a] <= smp;
          max_q[a] <= smp;
        end else begin
          sum_q[a] <= sum_q[a] + SW'(smp);
          if (smp < min_q[a]) begin
            min_q[a] <= smp;
          end
          if (smp > max_q[a]) begin
            max_q[a] <= smp;
          end
        end
      end
      if (div_done[a]) begin
        mean_q[a] <= quot[a];
      end
    end

    tmwf_div #(
      .DW (DW),
      .NW (NW)
    ) u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (div_start),
      .dividend_i (dvd),
      .divisor_i  (n_len - NW'(2)),
      .done_o     (div_done[a]),
      .quot_o     (quot[a])
    );
  end

  property p_one_side;
    @(posedge clk_i) disable iff (!rst_ni) out_if.valid |-> !in_if.ready;
  endproperty
  a_one_side: assert property (p_one_side) else $error("input taken while result pending");

  property p_cfg_restart;
    @(posedge clk_i) disable iff (!rst_ni) cfg_take |=> (wr_idx_q == '0) && !filled_q;
  endproperty
  a_cfg_restart: assert property (p_cfg_restart) else $error("config did not restart fill");

  property p_scan_needs_fill;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == tmwf_pkg::ST_SCAN) |-> filled_q;
  endproperty
  a_scan_needs_fill: assert property (p_scan_needs_fill) else $error("scan before window full");

  property p_read_in_range;
    @(posedge clk_i) disable iff (!rst_ni) issue |-> (rd_cnt_q < NW'(MAX_WINDOW));
  endproperty
  a_read_in_range: assert property (p_read_in_range) else $error("ring read out of range");

endmodule
